@@ rtl/sfa_pkg.sv @@
// ----------------------------------------------------------------------------
// sfa_pkg
// Shared widths, codes and controller/datapath bundles for the sprite frame
// animator.
// ----------------------------------------------------------------------------
package sfa_pkg;

    // field widths
    localparam int W_COMMAND  = 1;
    localparam int W_DELTA    = 16;
    localparam int W_OFFSET_U = 16;
    localparam int W_OFFSET_V = 18;
    localparam int W_SCALE    = 17;
    localparam int W_FRAME    = 12;
    localparam int W_GRID     = 8;
    localparam int W_PERIOD   = 20;
    localparam int W_ACC      = 21;
    localparam int W_CELL     = 13;

    // configuration port
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 20;

    typedef enum logic [CFG_AW-1:0] {
        CFG_GRID_COLUMNS = 3'd0,
        CFG_GRID_ROWS    = 3'd1,
        CFG_FRAME_TOTAL  = 3'd2,
        CFG_FIRST_FRAME  = 3'd3,
        CFG_LOOP_ENABLE  = 3'd4,
        CFG_FRAME_PERIOD = 3'd5
    } t_cfg_idx;

    localparam logic [W_PERIOD-1:0]   PERIOD_RESET = 20'd150000;
    localparam logic [W_SCALE-1:0]    ONE_Q16      = 17'd65536;
    localparam logic [W_OFFSET_V-1:0] OFFV_MAX     = 18'h3FFFF;

    // shared divider geometry
    localparam int DIV_NW = 29;   // widest dividend: row << 16
    localparam int DIV_DW = 20;   // widest divisor: frame period
    localparam int DIV_CW = 5;    // step count

    // steps per division (dividend width of each job)
    localparam logic [DIV_CW-1:0] STEPS_TIME = 5'd21;
    localparam logic [DIV_CW-1:0] STEPS_WRAP = 5'd21;
    localparam logic [DIV_CW-1:0] STEPS_CELL = 5'd13;
    localparam logic [DIV_CW-1:0] STEPS_SC   = 5'd17;
    localparam logic [DIV_CW-1:0] STEPS_OU   = 5'd24;
    localparam logic [DIV_CW-1:0] STEPS_OV   = 5'd29;

    // division jobs
    typedef enum logic [2:0] {
        SEL_TIME,   // accumulator / frame period
        SEL_WRAP,   // leftover frames modulo frame total
        SEL_CELL,   // cell / columns
        SEL_SU,     // 1.0 / columns
        SEL_SV,     // 1.0 / rows
        SEL_OU,     // column * 1.0 / columns
        SEL_OV      // row * 1.0 / rows
    } t_div_sel;

    // datapath operations
    typedef enum logic [2:0] {
        OP_NONE,
        OP_START,
        OP_ADD,
        OP_FRAME,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op      op;
        logic     div_go;
        t_div_sel div_sel;
    } t_cmd;

    typedef struct packed {
        logic is_start;
        logic advance;
        logic enabled;
        logic need_wrap;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

@@ rtl/sfa_if.sv @@
// ----------------------------------------------------------------------------
// sfa_if
// Valid/ready channels of the sprite frame animator: tick/start items in,
// UV results out.
// ----------------------------------------------------------------------------
interface sfa_in_if import sfa_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [W_COMMAND-1:0] command;
    logic [W_DELTA-1:0]   delta_us;

    modport source (output valid, output command, output delta_us, input ready);
    modport sink   (input valid, input command, input delta_us, output ready);
endinterface

interface sfa_out_if import sfa_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [W_OFFSET_U-1:0] offset_u;
    logic [W_OFFSET_V-1:0] offset_v;
    logic [W_SCALE-1:0]    scale_u;
    logic [W_SCALE-1:0]    scale_v;
    logic [W_FRAME-1:0]    frame_now;
    logic                  is_playing;

    modport source (output valid, output offset_u, output offset_v, output scale_u,
                    output scale_v, output frame_now, output is_playing, input ready);
    modport sink   (input valid, input offset_u, input offset_v, input scale_u,
                    input scale_v, input frame_now, input is_playing, output ready);
endinterface

@@ rtl/sprite_frame_animator_unit.sv @@
// ----------------------------------------------------------------------------
// sprite_frame_animator_unit
// Sprite-sheet frame animation: advances a frame counter from elapsed time
// and returns the UV offset and scale of the current grid cell.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one transaction per tick or start command; o_out returns one
//   result transaction for each. Both use valid/ready.
//   Configuration goes through i_cfg_we/i_cfg_addr/i_cfg_data while idle.
// Sequencing:
//   One shared divider produces one quotient bit per cycle and does all the
//   divisions, so the item time is set by its step counts. A disabled grid
//   skips the divider; a start or a non-advancing tick runs the cell, scale
//   and offset divisions; an advancing tick first divides the accumulated
//   time, and adds a wrap division when the frame wraps in a loop.
//   i_in.ready is high only between items, so a new item is taken only after
//   the last one has finished, and rises in the cycle before the result
//   shows up.
// Reset:
//   Synchronous, active low. Frame and accumulator clear, playing sets,
//   configuration takes its reset values and the output register empties.
// Back-pressure:
//   A finished result sits in the output register; the next item is taken
//   meanwhile, and its own result waits until that register is emptied.
// ----------------------------------------------------------------------------
module sprite_frame_animator_unit import sfa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sfa_in_if.sink            i_in,
    sfa_out_if.source         o_out,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;
    logic in_ready;
    logic in_accept;

    assign in_accept  = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    sfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_accept (in_accept),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_ready  (in_ready)
    );

    sfa_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_in_accept  (in_accept),
        .i_command    (i_in.command),
        .i_delta_us   (i_in.delta_us),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_offset_u   (o_out.offset_u),
        .o_offset_v   (o_out.offset_v),
        .o_scale_u    (o_out.scale_u),
        .o_scale_v    (o_out.scale_v),
        .o_frame_now  (o_out.frame_now),
        .o_is_playing (o_out.is_playing)
    );

endmodule

@@ rtl/sfa_div.sv @@
// ----------------------------------------------------------------------------
// sfa_div
// Shared restoring divider, one quotient bit per cycle, step count per job.
// ----------------------------------------------------------------------------
module sfa_div import sfa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic [DIV_NW-1:0] i_dividend,
    input  logic [DIV_DW-1:0] i_divisor,
    input  logic [DIV_CW-1:0] i_steps,
    output logic              o_done,
    output logic [DIV_NW-1:0] o_quot,
    output logic [DIV_DW-1:0] o_rem
);

    logic [DIV_NW-1:0] r_q;
    logic [DIV_DW-1:0] r_r;
    logic [DIV_CW-1:0] r_cnt;
    logic              r_done;

    logic [DIV_DW:0] rem_sh;
    logic [DIV_DW:0] diff;
    logic            fits;

    // trial subtract of the shifted partial remainder
    always_comb begin
        rem_sh = {r_r, r_q[DIV_NW-1]};
        diff   = rem_sh - {1'b0, i_divisor};
        fits   = rem_sh >= {1'b0, i_divisor};
    end

    // step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_cnt <= i_steps;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend left-aligned, quotient bits shift in from the bottom
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_q <= i_dividend << (DIV_CW'(DIV_NW) - i_steps);
            r_r <= '0;
        end else if (r_cnt != '0) begin
            r_q <= {r_q[DIV_NW-2:0], fits};
            r_r <= fits ? diff[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;

endmodule

@@ rtl/sfa_dp.sv @@
// ----------------------------------------------------------------------------
// sfa_dp
// Datapath: configuration registers, animation state, division operands and
// results, output register.
// ----------------------------------------------------------------------------
module sfa_dp import sfa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic                  i_in_accept,
    input  logic [W_COMMAND-1:0]  i_command,
    input  logic [W_DELTA-1:0]    i_delta_us,
    input  logic                  i_cfg_we,
    input  logic [CFG_AW-1:0]     i_cfg_addr,
    input  logic [CFG_DW-1:0]     i_cfg_data,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [W_OFFSET_U-1:0] o_offset_u,
    output logic [W_OFFSET_V-1:0] o_offset_v,
    output logic [W_SCALE-1:0]    o_scale_u,
    output logic [W_SCALE-1:0]    o_scale_v,
    output logic [W_FRAME-1:0]    o_frame_now,
    output logic                  o_is_playing
);

    // configuration
    logic [W_GRID-1:0]   r_cols;
    logic [W_GRID-1:0]   r_rows;
    logic [W_FRAME-1:0]  r_total;
    logic [W_FRAME-1:0]  r_first;
    logic                r_loop;
    logic [W_PERIOD-1:0] r_period;

    // captured item
    logic [W_COMMAND-1:0] r_command;
    logic [W_DELTA-1:0]   r_delta;

    // animation state
    logic [W_ACC-1:0]   r_acc;
    logic [W_FRAME-1:0] r_frame;
    logic               r_playing;

    // intermediate results
    logic [W_ACC-1:0]      r_n;
    logic [W_ACC-1:0]      r_m;
    logic [W_GRID-1:0]     r_col;
    logic [W_CELL-1:0]     r_row;
    logic [W_SCALE-1:0]    r_su;
    logic [W_SCALE-1:0]    r_sv;
    logic [W_OFFSET_U-1:0] r_ou;
    logic [W_OFFSET_V-1:0] r_ov;

    // output register
    logic                  r_out_valid;
    logic [W_OFFSET_U-1:0] r_o_ou;
    logic [W_OFFSET_V-1:0] r_o_ov;
    logic [W_SCALE-1:0]    r_o_su;
    logic [W_SCALE-1:0]    r_o_sv;
    logic [W_FRAME-1:0]    r_o_frame;
    logic                  r_o_playing;

    logic                  enabled;
    logic [W_CELL-1:0]     cell_num;
    logic [W_ACC:0]        sum_fn;
    logic                  below;
    logic [W_FRAME-1:0]    k_wrap;
    logic [W_ACC-1:0]      m_next;
    logic [DIV_NW-1:0]     div_dividend;
    logic [DIV_DW-1:0]     div_divisor;
    logic [DIV_CW-1:0]     div_steps;
    logic                  div_done;
    logic [DIV_NW-1:0]     div_quot;
    logic [DIV_DW-1:0]     div_rem;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols   <= '0;
            r_rows   <= '0;
            r_total  <= '0;
            r_first  <= '0;
            r_loop   <= 1'b1;
            r_period <= PERIOD_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_GRID_COLUMNS: r_cols   <= i_cfg_data[W_GRID-1:0];
                CFG_GRID_ROWS:    r_rows   <= i_cfg_data[W_GRID-1:0];
                CFG_FRAME_TOTAL:  r_total  <= i_cfg_data[W_FRAME-1:0];
                CFG_FIRST_FRAME:  r_first  <= i_cfg_data[W_FRAME-1:0];
                CFG_LOOP_ENABLE:  r_loop   <= i_cfg_data[0];
                CFG_FRAME_PERIOD: r_period <= i_cfg_data[W_PERIOD-1:0];
                default: ;
            endcase
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_in_accept) begin
            r_command <= i_command;
            r_delta   <= i_delta_us;
        end
    end

    // frame advance arithmetic
    always_comb begin
        enabled  = (r_cols != '0) && (r_rows != '0) && (r_total != '0);
        cell_num = W_CELL'(r_first) + W_CELL'(r_frame);
        sum_fn   = (W_ACC+1)'(r_frame) + (W_ACC+1)'(r_n);
        below    = sum_fn < (W_ACC+1)'(r_total);
        k_wrap   = (r_frame < r_total) ? (r_total - r_frame) : W_FRAME'(1);
        m_next   = r_n - W_ACC'(k_wrap);
    end

    // divider operands for the running job
    always_comb begin
        div_dividend = '0;
        div_divisor  = DIV_DW'(r_cols);
        div_steps    = STEPS_CELL;
        case (i_cmd.div_sel) inside
            SEL_TIME: begin
                div_dividend = DIV_NW'(r_acc);
                div_divisor  = r_period;
                div_steps    = STEPS_TIME;
            end
            SEL_WRAP: begin
                div_dividend = DIV_NW'(r_m);
                div_divisor  = DIV_DW'(r_total);
                div_steps    = STEPS_WRAP;
            end
            SEL_CELL: begin
                div_dividend = DIV_NW'(cell_num);
                div_divisor  = DIV_DW'(r_cols);
                div_steps    = STEPS_CELL;
            end
            SEL_SU, SEL_SV: begin
                div_dividend = DIV_NW'(ONE_Q16);
                div_divisor  = (i_cmd.div_sel == SEL_SU) ? DIV_DW'(r_cols) : DIV_DW'(r_rows);
                div_steps    = STEPS_SC;
            end
            SEL_OU: begin
                div_dividend = DIV_NW'({r_col, 16'h0000});
                div_divisor  = DIV_DW'(r_cols);
                div_steps    = STEPS_OU;
            end
            SEL_OV: begin
                div_dividend = {r_row, 16'h0000};
                div_divisor  = DIV_DW'(r_rows);
                div_steps    = STEPS_OV;
            end
            default: ;
        endcase
    end

    sfa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (i_cmd.div_go),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .i_steps    (div_steps),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // animation state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_frame   <= '0;
            r_playing <= 1'b1;
        end else begin
            if (i_cmd.op == OP_START) begin
                r_acc     <= '0;
                r_frame   <= '0;
                r_playing <= 1'b1;
            end else if (i_cmd.op == OP_ADD) begin
                r_acc <= r_acc + W_ACC'(r_delta);
            end else if (i_cmd.op == OP_FRAME && r_n != '0) begin
                // no wrap, wrap handled by the divider, or stop on the last frame
                if (below) begin
                    r_frame <= sum_fn[W_FRAME-1:0];
                end else if (!r_loop) begin
                    r_frame   <= r_total - W_FRAME'(1);
                    r_playing <= 1'b0;
                end
            end
            if (div_done && i_cmd.div_sel == SEL_TIME) begin
                r_acc <= W_ACC'(div_rem);
            end
            if (div_done && i_cmd.div_sel == SEL_WRAP) begin
                r_frame <= div_rem[W_FRAME-1:0];
            end
        end
    end

    // division results
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_FRAME) begin
            r_m <= m_next;
        end
        if (div_done) begin
            case (i_cmd.div_sel)
                SEL_TIME: r_n <= div_quot[W_ACC-1:0];
                SEL_CELL: begin
                    r_col <= div_rem[W_GRID-1:0];
                    r_row <= div_quot[W_CELL-1:0];
                end
                SEL_SU:   r_su <= div_quot[W_SCALE-1:0];
                SEL_SV:   r_sv <= div_quot[W_SCALE-1:0];
                SEL_OU:   r_ou <= div_quot[W_OFFSET_U-1:0];
                SEL_OV:   r_ov <= (div_quot[DIV_NW-1:W_OFFSET_V] != '0) ? OFFV_MAX
                                  : div_quot[W_OFFSET_V-1:0];
                default: ;
            endcase
        end
    end

    // output register, refilled once the previous transaction is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_EMIT) begin
            r_o_ou      <= enabled ? r_ou : '0;
            r_o_ov      <= enabled ? r_ov : '0;
            r_o_su      <= enabled ? r_su : ONE_Q16;
            r_o_sv      <= enabled ? r_sv : ONE_Q16;
            r_o_frame   <= r_frame;
            r_o_playing <= r_playing;
        end
    end

    // status to the controller
    always_comb begin
        o_sts.is_start  = r_command[0];
        o_sts.advance   = enabled && r_playing && (r_period != '0) && (r_delta != '0);
        o_sts.enabled   = enabled;
        o_sts.need_wrap = r_loop && (r_n != '0) && !below;
        o_sts.div_done  = div_done;
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid  = r_out_valid;
    assign o_offset_u   = r_o_ou;
    assign o_offset_v   = r_o_ov;
    assign o_scale_u    = r_o_su;
    assign o_scale_v    = r_o_sv;
    assign o_frame_now  = r_o_frame;
    assign o_is_playing = r_o_playing;

endmodule

@@ rtl/sfa_ctrl.sv @@
// ----------------------------------------------------------------------------
// sfa_ctrl
// Controller: sequences state update, divider jobs and result hand-off.
// ----------------------------------------------------------------------------
module sfa_ctrl import sfa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_accept,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_ready
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_START,
        S_ADD,
        S_TIME,
        S_FRAME,
        S_WRAP,
        S_CELL,
        S_SU,
        S_SV,
        S_OU,
        S_OV,
        S_EMIT
    } t_state;

    t_state r_state;
    t_cmd   r_cmd;
    logic   r_ready;

    // state, command and ready, all registered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_ready         <= 1'b1;
            r_cmd.op        <= OP_NONE;
            r_cmd.div_go    <= 1'b0;
            r_cmd.div_sel   <= SEL_TIME;
        end else begin
            r_cmd.op     <= OP_NONE;
            r_cmd.div_go <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_accept) begin
                        r_ready <= 1'b0;
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    if (i_sts.is_start) begin
                        r_cmd.op <= OP_START;
                        r_state  <= S_START;
                    end else if (i_sts.advance) begin
                        r_cmd.op <= OP_ADD;
                        r_state  <= S_ADD;
                    end else if (i_sts.enabled) begin
                        r_cmd.div_go  <= 1'b1;
                        r_cmd.div_sel <= SEL_CELL;
                        r_state       <= S_CELL;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_START: begin
                    if (i_sts.enabled) begin
                        r_cmd.div_go  <= 1'b1;
                        r_cmd.div_sel <= SEL_CELL;
                        r_state       <= S_CELL;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_ADD: begin
                    r_cmd.div_go  <= 1'b1;
                    r_cmd.div_sel <= SEL_TIME;
                    r_state       <= S_TIME;
                end
                S_TIME: begin
                    if (i_sts.div_done) begin
                        r_cmd.op <= OP_FRAME;
                        r_state  <= S_FRAME;
                    end
                end
                S_FRAME: begin
                    r_cmd.div_go <= 1'b1;
                    if (i_sts.need_wrap) begin
                        r_cmd.div_sel <= SEL_WRAP;
                        r_state       <= S_WRAP;
                    end else begin
                        r_cmd.div_sel <= SEL_CELL;
                        r_state       <= S_CELL;
                    end
                end
                S_WRAP: begin
                    if (i_sts.div_done) begin
                        r_cmd.div_go  <= 1'b1;
                        r_cmd.div_sel <= SEL_CELL;
                        r_state       <= S_CELL;
                    end
                end
                S_CELL: begin
                    if (i_sts.div_done) begin
                        r_cmd.div_go  <= 1'b1;
                        r_cmd.div_sel <= SEL_SU;
                        r_state       <= S_SU;
                    end
                end
                S_SU: begin
                    if (i_sts.div_done) begin
                        r_cmd.div_go  <= 1'b1;
                        r_cmd.div_sel <= SEL_SV;
                        r_state       <= S_SV;
                    end
                end
                S_SV: begin
                    if (i_sts.div_done) begin
                        r_cmd.div_go  <= 1'b1;
                        r_cmd.div_sel <= SEL_OU;
                        r_state       <= S_OU;
                    end
                end
                S_OU: begin
                    if (i_sts.div_done) begin
                        r_cmd.div_go  <= 1'b1;
                        r_cmd.div_sel <= SEL_OV;
                        r_state       <= S_OV;
                    end
                end
                S_OV: begin
                    if (i_sts.div_done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (i_sts.out_free) begin
                        r_cmd.op <= OP_EMIT;
                        r_ready  <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_ready <= 1'b1;
                end
            endcase
        end
    end

    assign o_cmd      = r_cmd;
    assign o_in_ready = r_ready;

endmodule

@@ rtl/sfa_chk.sv @@
// ----------------------------------------------------------------------------
// sfa_chk
// Port-level checks of the sprite frame animator, bound to the top level.
// ----------------------------------------------------------------------------
module sfa_chk import sfa_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [W_OFFSET_U-1:0] i_offset_u,
    input logic [W_SCALE-1:0]    i_scale_u,
    input logic [W_FRAME-1:0]    i_frame_now,
    input logic                  i_is_playing
);

    // result holds while the receiver stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_offset_u) && $stable(i_frame_now) && $stable(i_is_playing))
        else $error("result changed while stalled");

    // no result straight out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // one item at a time: ready drops after an accepted transaction
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second item taken while busy");

    // full-width scale means a single column or disabled grid: offset is zero
    a_scale_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_scale_u == ONE_Q16) |-> i_offset_u == '0)
        else $error("nonzero offset with unit scale");

endmodule

bind sprite_frame_animator_unit sfa_chk u_sfa_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_offset_u   (o_out.offset_u),
    .i_scale_u    (o_out.scale_u),
    .i_frame_now  (o_out.frame_now),
    .i_is_playing (o_out.is_playing)
);

@@ tb/sfa_tb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfa_tb_pkg
// Command codes shared by the stimulus and the checker of the sprite frame
// animator testbench.
// ----------------------------------------------------------------------------
package sfa_tb_pkg;
    import sfa_pkg::*;

    // input command field
    typedef enum logic [W_COMMAND-1:0] {
        CMD_TICK  = 1'b0,
        CMD_START = 1'b1
    } t_command;

endpackage

@@ tb/sfa_uv_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfa_uv_checker
// Watches the input, output and configuration ports of the sprite frame
// animator, predicts the UV result of every accepted transaction and compares
// each returned result with the oldest prediction.
// ----------------------------------------------------------------------------
module sfa_uv_checker import sfa_pkg::*; import sfa_tb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sfa_in_if                 i_in,
    sfa_out_if                i_out,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_data,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked
);

    localparam int MAX_REPORTS = 60;

    typedef struct packed {
        logic [W_OFFSET_U-1:0] offset_u;
        logic [W_OFFSET_V-1:0] offset_v;
        logic [W_SCALE-1:0]    scale_u;
        logic [W_SCALE-1:0]    scale_v;
        logic [W_FRAME-1:0]    frame_now;
        logic                  is_playing;
    } t_uv_result;

    // shadow configuration
    logic [W_GRID-1:0]   grid_cols;
    logic [W_GRID-1:0]   grid_rows;
    logic [W_FRAME-1:0]  frame_total;
    logic [W_FRAME-1:0]  first_frame;
    logic                loop_on;
    logic [W_PERIOD-1:0] frame_period;

    // shadow animation state
    logic [W_ACC-1:0]    time_accum;
    logic [W_FRAME-1:0]  frame_idx;
    logic                playing;

    t_uv_result uv_expected[$];
    t_uv_result want;
    int         fail_count = 0;
    int         checked = 0;
    int         pending_cnt = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_cnt;
    assign o_checked    = checked;

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("[%0t] MISMATCH %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] got_val);
        if (got_val !== exp_val) begin
            report_mismatch($sformatf("result %0d: %s expected %0d, got %0d",
                                      checked, name, exp_val, got_val));
        end
    endtask

    // update the animation for one transaction and work out its uv result
    function automatic t_uv_result predict_uv(input t_command cmd,
                                              input logic [W_DELTA-1:0] delta);
        t_uv_result       r;
        logic [W_ACC-1:0] sum;
        logic             enabled;
        int unsigned      steps;
        int unsigned      run;
        int unsigned      frm;
        int unsigned      cell_idx;
        int unsigned      col;
        int unsigned      row;
        int unsigned      v;
        int unsigned      one_q16;
        one_q16 = ONE_Q16;
        enabled = (grid_cols != 0) && (grid_rows != 0) && (frame_total != 0);
        if (cmd == CMD_START) begin
            frame_idx  = '0;
            time_accum = '0;
            playing    = 1'b1;
        end else if (enabled && playing && frame_period != 0 && delta != 0) begin
            sum        = time_accum + delta;
            steps      = sum / frame_period;
            time_accum = sum % frame_period;
            frm        = frame_idx;
            // skip straight runs of frames, reduce whole loops at once
            while (steps != 0) begin
                if (frm + 1 < frame_total) begin
                    run = frame_total - 1 - frm;
                    if (run > steps) run = steps;
                    frm   += run;
                    steps -= run;
                end else if (loop_on) begin
                    frm   = 0;
                    steps = (steps - 1) % frame_total;
                end else begin
                    frm     = frame_total - 1;
                    playing = 1'b0;
                    steps   = 0;
                end
            end
            frame_idx = frm[W_FRAME-1:0];
        end

        r.offset_u = '0;
        r.offset_v = '0;
        r.scale_u  = ONE_Q16;
        r.scale_v  = ONE_Q16;
        if (enabled) begin
            cell_idx   = first_frame + frame_idx;
            col        = cell_idx % grid_cols;
            row        = cell_idx / grid_cols;
            r.scale_u  = W_SCALE'(one_q16 / grid_cols);
            r.scale_v  = W_SCALE'(one_q16 / grid_rows);
            r.offset_u = W_OFFSET_U'((col * one_q16) / grid_cols);
            v          = (row * one_q16) / grid_rows;
            r.offset_v = (v > OFFV_MAX) ? OFFV_MAX : v[W_OFFSET_V-1:0];
        end
        r.frame_now  = frame_idx;
        r.is_playing = playing;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            grid_cols    = '0;
            grid_rows    = '0;
            frame_total  = '0;
            first_frame  = '0;
            loop_on      = 1'b1;
            frame_period = PERIOD_RESET;
            time_accum   = '0;
            frame_idx    = '0;
            playing      = 1'b1;
            uv_expected.delete();
        end else begin
            // result transaction against the oldest prediction
            if (i_out.valid && i_out.ready) begin
                checked++;
                if (uv_expected.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              checked));
                end else begin
                    want = uv_expected.pop_front();
                    check_field("offset_u", want.offset_u, i_out.offset_u);
                    check_field("offset_v", want.offset_v, i_out.offset_v);
                    check_field("scale_u", want.scale_u, i_out.scale_u);
                    check_field("scale_v", want.scale_v, i_out.scale_v);
                    check_field("frame_now", want.frame_now, i_out.frame_now);
                    check_field("is_playing", want.is_playing, i_out.is_playing);
                end
            end
            // input transaction
            if (i_in.valid && i_in.ready) begin
                uv_expected.push_back(predict_uv(t_command'(i_in.command), i_in.delta_us));
            end
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_GRID_COLUMNS: grid_cols    = i_cfg_data[W_GRID-1:0];
                    CFG_GRID_ROWS:    grid_rows    = i_cfg_data[W_GRID-1:0];
                    CFG_FRAME_TOTAL:  frame_total  = i_cfg_data[W_FRAME-1:0];
                    CFG_FIRST_FRAME:  first_frame  = i_cfg_data[W_FRAME-1:0];
                    CFG_LOOP_ENABLE:  loop_on      = i_cfg_data[0];
                    CFG_FRAME_PERIOD: frame_period = i_cfg_data[W_PERIOD-1:0];
                    default: ;
                endcase
            end
        end
        pending_cnt = uv_expected.size();
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives tick and start transactions into the sprite frame animator under
// several grid settings, directed corners first and then random phases, with
// random gaps and back-pressure; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;
    import sfa_pkg::*;
    import sfa_tb_pkg::*;

    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int MAX_GAP         = 16;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 300;
    localparam int CYCLE_LIMIT     = 1_000_000;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              cfg_we;
    logic [CFG_AW-1:0] cfg_addr;
    logic [CFG_DW-1:0] cfg_data;

    int          fail_count;
    int          pending;
    int          checked;
    int          sent = 0;
    int          settings = 0;
    int          cycles = 0;
    bit          gaps_on;
    bit          stalls_on;
    int unsigned cur_period;

    sfa_in_if  in_ch ();
    sfa_out_if out_ch ();

    sprite_frame_animator_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_addr (cfg_addr),
        .i_cfg_data (cfg_data)
    );

    sfa_uv_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("testbench NOT OK");
            $finish;
        end
    end

    // result receiver with random stalls
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = stalls_on ? $urandom_range(0, MAX_GAP) : 0;
            if (stall != 0) begin
                out_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
            @(negedge i_clk);
        end
    end

    // one input transaction, after a random gap
    task automatic send_item(input t_command cmd, input logic [W_DELTA-1:0] delta);
        int gap;
        gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid    = 1'b1;
        in_ch.command  = cmd;
        in_ch.delta_us = delta;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        @(negedge i_clk);
        sent++;
    endtask

    // hold off until every result is back and the block is idle
    task automatic settle_all();
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int unsigned value);
        cfg_we   = 1'b1;
        cfg_addr = idx;
        cfg_data = value[CFG_DW-1:0];
        @(negedge i_clk);
        cfg_we   = 1'b0;
        if (idx == CFG_FRAME_PERIOD) cur_period = value;
    endtask

    task automatic program_grid(input int unsigned cols, input int unsigned rows,
                                input int unsigned total, input int unsigned first,
                                input int unsigned loop_val, input int unsigned period);
        settle_all();
        write_reg(CFG_GRID_COLUMNS, cols);
        write_reg(CFG_GRID_ROWS, rows);
        write_reg(CFG_FRAME_TOTAL, total);
        write_reg(CFG_FIRST_FRAME, first);
        write_reg(CFG_LOOP_ENABLE, loop_val);
        write_reg(CFG_FRAME_PERIOD, period);
        settings++;
    endtask

    // random picks biased toward the corners
    function automatic int unsigned rand_dim();
        int unsigned k;
        k = $urandom_range(0, 19);
        if (k == 0) return 0;
        if (k <= 3) return 1;
        if (k <= 6) return 255;
        if (k <= 12) return $urandom_range(2, 8);
        return $urandom_range(1, 255);
    endfunction

    function automatic int unsigned rand_total();
        int unsigned k;
        k = $urandom_range(0, 19);
        if (k == 0) return 0;
        if (k <= 2) return 1;
        if (k <= 4) return 4095;
        if (k <= 12) return $urandom_range(2, 16);
        return $urandom_range(1, 4095);
    endfunction

    function automatic int unsigned rand_first();
        int unsigned k;
        k = $urandom_range(0, 4);
        if (k == 0) return 0;
        if (k == 1) return 4095;
        if (k == 2) return $urandom_range(0, 32);
        return $urandom_range(0, 4095);
    endfunction

    function automatic int unsigned rand_period();
        int unsigned k;
        k = $urandom_range(0, 19);
        if (k == 0) return 0;
        if (k == 1) return 1;
        if (k == 2) return 20'hFFFFF;
        if (k <= 9) return $urandom_range(2, 2000);
        if (k <= 15) return $urandom_range(2000, 70000);
        return $urandom_range(1, 20'hFFFFF);
    endfunction

    // half the time, when the period allows, deltas up to twice the period so frames step at most two at a time
    function automatic logic [W_DELTA-1:0] rand_delta();
        int unsigned k;
        int unsigned lim;
        k = $urandom_range(0, 15);
        if (k == 0) return '0;
        if (k == 1) return '1;
        if (k <= 9 && cur_period != 0 && cur_period <= 32767) begin
            lim = 2 * cur_period;
            return W_DELTA'($urandom_range(0, lim));
        end
        return W_DELTA'($urandom_range(0, 65535));
    endfunction

    initial begin
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_addr       = CFG_GRID_COLUMNS;
        cfg_data       = '0;
        in_ch.valid    = 1'b0;
        in_ch.command  = CMD_TICK;
        in_ch.delta_us = '0;
        gaps_on        = 1'b1;
        stalls_on      = 1'b1;
        cur_period     = PERIOD_RESET;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset configuration: grid disabled
        send_item(CMD_TICK, 16'hFFFF);
        send_item(CMD_START, 16'h0000);

        // small looping grid: no advance, exact period, one frame, many frames with wrap
        program_grid(4, 4, 10, 3, 1, 1000);
        send_item(CMD_START, 16'hFFFF);
        send_item(CMD_TICK, 16'd0);
        send_item(CMD_TICK, 16'd999);
        send_item(CMD_TICK, 16'd1);
        send_item(CMD_TICK, 16'hFFFF);
        send_item(CMD_TICK, 16'd12345);

        // no looping: stop on last frame, stopped ticks, restart
        settle_all();
        write_reg(CFG_LOOP_ENABLE, 0);
        send_item(CMD_TICK, 16'hFFFF);
        send_item(CMD_TICK, 16'd40000);
        send_item(CMD_START, 16'd7);
        send_item(CMD_TICK, 16'd500);

        // frame past a lowered total, looping then stopping
        program_grid(5, 3, 20, 0, 1, 100);
        send_item(CMD_START, 16'd0);
        send_item(CMD_TICK, 16'd1500);
        settle_all();
        write_reg(CFG_FRAME_TOTAL, 5);
        send_item(CMD_TICK, 16'd100);
        settle_all();
        write_reg(CFG_FRAME_TOTAL, 20);
        send_item(CMD_START, 16'd0);
        send_item(CMD_TICK, 16'd1500);
        settle_all();
        write_reg(CFG_FRAME_TOTAL, 5);
        write_reg(CFG_LOOP_ENABLE, 0);
        send_item(CMD_TICK, 16'd100);

        // widest grid and longest period
        program_grid(255, 255, 4095, 4095, 0, 20'hFFFFF);
        send_item(CMD_TICK, 16'hFFFF);
        send_item(CMD_START, 16'hFFFF);

        // one-cell grid: saturated v offset, huge advance, zero period, disables
        program_grid(1, 1, 4095, 4095, 1, 1);
        send_item(CMD_TICK, 16'hFFFF);
        settle_all();
        write_reg(CFG_FRAME_PERIOD, 0);
        send_item(CMD_TICK, 16'hFFFF);
        settle_all();
        write_reg(CFG_GRID_ROWS, 0);
        send_item(CMD_TICK, 16'd1);
        settle_all();
        write_reg(CFG_GRID_ROWS, 1);
        write_reg(CFG_FRAME_TOTAL, 0);
        send_item(CMD_TICK, 16'd1);

        // random phases, each a fresh grid with a start and then mostly ticks
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            program_grid(rand_dim(), rand_dim(), rand_total(), rand_first(),
                         $urandom_range(0, 1), rand_period());
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            send_item(CMD_START, W_DELTA'($urandom));
            for (int i = 1; i < ITEMS_PER_PHASE; i++) begin
                if (i == ITEMS_PER_PHASE / 2) begin
                    if (phase == 2) begin
                        settle_all();
                    end else if (phase % 3 == 1) begin
                        // change the total mid-animation
                        settle_all();
                        write_reg(CFG_FRAME_TOTAL, rand_total());
                    end
                end
                if ($urandom_range(0, 15) == 0) begin
                    send_item(CMD_START, W_DELTA'($urandom));
                end else begin
                    send_item(CMD_TICK, rand_delta());
                end
            end
        end

        settle_all();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("sent %0d transactions over %0d grid settings, %0d results compared",
                 sent, settings, checked);
        $display("corners: disabled grid, wrap, stop, frame past total, v saturation, zero period");
        if (fail_count == 0 && pending == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
